// ----- rtl/tbs_pkg.sv -----
// Shared constants, codes and types of the tolerance bracket search.
package tbs_pkg;

  localparam int MAX_PICKS = 64;
  localparam int NUM_KINDS = 4;
  localparam int DEPTH     = NUM_KINDS * MAX_PICKS;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int IDX_W     = $clog2(MAX_PICKS);
  localparam int CNT_W     = $clog2(MAX_PICKS + 1);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] REG_PICK_COUNT  = 2'd0;
  localparam logic [1:0] REG_SCREEN_TOL  = 2'd1;
  localparam logic [1:0] REG_FIXED_TOL   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_NEIGH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic               use_screen_tol;
    logic signed [31:0] time_value;
    logic [5:0]         entry_index;
    logic [1:0]         kind;
    logic               op;
  } item_t;

  typedef struct packed {
    logic [30:0]        tol;
    logic signed [31:0] upper_base;
    logic               has_upper;
    logic signed [31:0] lower_base;
    logic               has_lower;
    logic [6:0]         pick_index;
    logic               is_insert;
  } res_t;

endpackage

// ----- rtl/tbs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/tbs_ctrl.sv -----
// Scan sequencer: loads, table scan one entry per cycle, neighbour fetch.
module tbs_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  tbs_pkg::item_t             item,
  input  logic [6:0]                 pick_count,
  input  logic [30:0]                screen_tolerance,
  input  logic [30:0]                fixed_tolerance,
  output logic                       ram_we,
  output logic [tbs_pkg::ADDR_W-1:0] ram_waddr,
  output logic [31:0]                ram_wdata,
  output logic                       ram_re,
  output logic [tbs_pkg::ADDR_W-1:0] ram_raddr,
  input  logic [31:0]                ram_rdata,
  output tbs_pkg::res_t              res,
  output logic                       res_valid,
  input  logic                       res_ready
);
  import tbs_pkg::*;

  state_t             state;
  state_t             state_next;
  logic signed [31:0] t;
  logic [30:0]        tol;
  logic [CNT_W-1:0]   cnt;
  logic [ADDR_W-1:0]  base;
  logic [IDX_W-1:0]   i;
  logic signed [31:0] prev;
  logic               fb_found;
  logic [IDX_W-1:0]   fb_idx;
  logic signed [31:0] fb_lo;
  logic signed [31:0] fb_hi;

  logic               accept;
  logic signed [31:0] p;
  logic signed [33:0] diff;
  logic signed [33:0] tol_ext;
  logic               hit;
  logic               bigger;
  logic               last;
  logic [CNT_W-1:0]   cnt_in;
  logic               kind_ok;
  logic [30:0]        tol_sel;

  assign accept  = in_valid && in_ready;
  assign p       = signed'(ram_rdata);
  assign diff    = {{2{p[31]}}, p} - {{2{t[31]}}, t};
  assign tol_ext = signed'({3'b000, tol});
  assign hit     = (diff <= tol_ext) && (diff >= -tol_ext);
  assign bigger  = p > t;
  assign last    = (CNT_W'(i) + CNT_W'(1)) == cnt;
  assign kind_ok = int'(item.kind) < NUM_KINDS;
  assign tol_sel = item.use_screen_tol ? screen_tolerance : fixed_tolerance;

  always_comb begin
    if (!kind_ok) begin
      cnt_in = '0;
    end else if (int'(pick_count) > MAX_PICKS) begin
      cnt_in = CNT_W'(MAX_PICKS);
    end else begin
      cnt_in = CNT_W'(pick_count);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (item.op == OP_QUERY && cnt_in != '0) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_next = last ? ST_DONE : ST_NEIGH;
        end else if (last) begin
          state_next = ST_DONE;
        end
      end
      ST_NEIGH: state_next = ST_DONE;
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = base + ADDR_W'(i) + ADDR_W'(1);
    ram_waddr = ADDR_W'(int'(item.kind) * MAX_PICKS + int'(item.entry_index));
    ram_wdata = item.time_value;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        ram_raddr = ADDR_W'(int'(item.kind) * MAX_PICKS);
        ram_re    = in_valid && item.op == OP_QUERY;
        ram_we    = in_valid && item.op == OP_LOAD && kind_ok &&
                    int'(item.entry_index) < MAX_PICKS;
      end
      ST_SCAN:  ram_re = 1'b1;
      ST_NEIGH: ram_re = 1'b0;
      ST_DONE:  res_valid = 1'b1;
      default:  in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          t        <= item.time_value;
          tol      <= tol_sel;
          cnt      <= cnt_in;
          base     <= ADDR_W'(int'(item.kind) * MAX_PICKS);
          i        <= '0;
          fb_found <= 1'b0;
          if (item.op == OP_QUERY) begin
            res <= {tol_sel, 32'd0, 1'b0, 32'd0, 1'b0, 7'd0, 1'b1};
          end else begin
            res <= '0;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          res.is_insert  <= 1'b0;
          res.pick_index <= 7'(i);
          res.has_lower  <= i != '0;
          res.lower_base <= prev;
          res.has_upper  <= !last;
        end else begin
          prev <= p;
          i    <= i + IDX_W'(1);
          if (!fb_found && bigger) begin
            fb_found <= 1'b1;
            fb_idx   <= i;
            fb_lo    <= prev;
            fb_hi    <= p;
          end
          if (last) begin
            res.is_insert <= 1'b1;
            if (fb_found) begin
              res.pick_index <= 7'(fb_idx);
              res.has_lower  <= fb_idx != '0;
              res.lower_base <= fb_lo;
              res.has_upper  <= 1'b1;
              res.upper_base <= fb_hi;
            end else if (bigger) begin
              res.pick_index <= 7'(i);
              res.has_lower  <= i != '0;
              res.lower_base <= prev;
              res.has_upper  <= 1'b1;
              res.upper_base <= p;
            end else begin
              res.pick_index <= 7'(cnt);
              res.has_lower  <= 1'b1;
              res.lower_base <= p;
              res.has_upper  <= 1'b0;
            end
          end
        end
      end
      ST_NEIGH: res.upper_base <= p;
      ST_DONE:  res.tol <= res.tol;
      default:  res <= res;
    endcase
  end

endmodule

// ----- rtl/tbs_out.sv -----
// Output register: applies tolerance to the neighbours with saturation.
module tbs_out (
  input  logic          clk,
  input  logic          rst,
  input  tbs_pkg::res_t res,
  input  logic          res_valid,
  output logic          res_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [79:0]   out_data,
  output logic [0:0]    out_user
);
  import tbs_pkg::*;

  logic signed [33:0] lo_sum;
  logic signed [33:0] hi_sum;
  logic signed [31:0] lo_sat;
  logic signed [31:0] hi_sat;
  logic signed [33:0] tol_ext;

  localparam logic signed [33:0] S32_MAX = 34'sh0_7FFF_FFFF;
  localparam logic signed [33:0] S32_MIN = -34'sh0_8000_0000;

  assign tol_ext   = signed'({3'b000, res.tol});
  assign lo_sum    = {{2{res.lower_base[31]}}, res.lower_base} + tol_ext;
  assign hi_sum    = {{2{res.upper_base[31]}}, res.upper_base} - tol_ext;
  assign res_ready = !out_valid || out_ready;

  always_comb begin
    if (!res.has_lower) begin
      lo_sat = '0;
    end else if (lo_sum > S32_MAX) begin
      lo_sat = 32'sh7FFF_FFFF;
    end else if (lo_sum < S32_MIN) begin
      lo_sat = 32'sh8000_0000;
    end else begin
      lo_sat = lo_sum[31:0];
    end
    if (!res.has_upper) begin
      hi_sat = '0;
    end else if (hi_sum > S32_MAX) begin
      hi_sat = 32'sh7FFF_FFFF;
    end else if (hi_sum < S32_MIN) begin
      hi_sat = 32'sh8000_0000;
    end else begin
      hi_sat = hi_sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_user <= res.is_insert;
      out_data <= {7'b0, hi_sat, res.has_upper, lo_sat, res.has_lower, res.pick_index};
    end
  end

endmodule

// ----- rtl/tolerance_bracket_search.sv -----
// Top level of the tolerance bracket search: ports, registers, RAM and sequencer.
//
// Holds four tables of 64 ascending Q16.16 pick times in one 256-word RAM.
// A load item writes one entry and returns an all-zero result through the
// done state and the output register. A query scans entries 0 to count-1 of
// its kind's table, count being pick_count capped at 64, one read per cycle
// through the single RAM read port, stopping at the first entry within the
// tolerance. The next item is taken in the cycle after the result enters the
// output register. Reading an entry never loaded since reset gives an
// undefined result. Configuration writes are taken at any time but belong
// between items.
module tolerance_bracket_search (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // entry_index[5:0], time_value[37:6], use_screen_tol[38], zero pad
  input  logic [39:0] s_axis_tdata,
  // op[0], kind[2:1]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pick_index[6:0], has_lower[7], lower_limit[39:8], has_upper[40],
  // upper_limit[72:41], zero pad
  output logic [79:0] m_axis_tdata,
  // is_insert[0]
  output logic [0:0]  m_axis_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import tbs_pkg::*;

  logic [6:0]        pick_count;
  logic [30:0]       screen_tolerance;
  logic [30:0]       fixed_tolerance;
  item_t             item;
  res_t              res;
  logic              res_valid;
  logic              res_ready;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [31:0]       ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [31:0]       ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pick_count       <= '0;
      screen_tolerance <= '0;
      fixed_tolerance  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PICK_COUNT: pick_count       <= cfg_data[6:0];
        REG_SCREEN_TOL: screen_tolerance <= cfg_data[30:0];
        REG_FIXED_TOL:  fixed_tolerance  <= cfg_data[30:0];
        default:        pick_count       <= pick_count;
      endcase
    end
  end

  assign item.op             = s_axis_tuser[0];
  assign item.kind           = s_axis_tuser[2:1];
  assign item.entry_index    = s_axis_tdata[5:0];
  assign item.time_value     = signed'(s_axis_tdata[37:6]);
  assign item.use_screen_tol = s_axis_tdata[38];

  tbs_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  tbs_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_axis_tvalid),
    .in_ready        (s_axis_tready),
    .item            (item),
    .pick_count      (pick_count),
    .screen_tolerance(screen_tolerance),
    .fixed_tolerance (fixed_tolerance),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_re          (ram_re),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata),
    .res             (res),
    .res_valid       (res_valid),
    .res_ready       (res_ready)
  );

  tbs_out u_out (
    .clk      (clk),
    .rst      (rst),
    .res      (res),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (m_axis_tdata),
    .out_user (m_axis_tuser)
  );

endmodule
